@@ hdl/sync_length_deframer_top_defines.svh @@
// ----------------------------------------------------------------------------
// sync_length_deframer_top_defines
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off in reset
`define SLD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, sampled on clock, off in reset
`define SLD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

@@ hdl/sld_pkg.sv @@
// ----------------------------------------------------------------------------
// sld_pkg
// shared types and constants of the sync/length deframer
// ----------------------------------------------------------------------------
package sld_pkg;

   typedef enum logic [2:0] {
      PH_SYNC0   = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_SYNC2   = 3'd2,
      PH_SYNC3   = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_LEN_ERR = 1'b1;

   localparam logic CSR_SYNC_WORD   = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [31:0] SYNC_WORD_RESET   = 32'hEB90_FD0D;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_offset;
      logic        frame_last;
      logic [15:0] frame_length;
   } result_type;

endpackage

@@ hdl/sld_core.sv @@
// ----------------------------------------------------------------------------
// sld_core
// frame state machine: sync hunt, length capture and payload count
// ----------------------------------------------------------------------------
module sld_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         rx_byte,
   input  logic [31:0]        sync_word,
   input  logic [15:0]        max_payload,
   output logic               has_result,
   output sld_pkg::result_type result
);
   import sld_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  expect_byte;
   logic [16:0] count_next;
   logic        last;

   always_comb begin
      unique case (phase_ff)
         PH_SYNC0: expect_byte = sync_word[31:24];
         PH_SYNC1: expect_byte = sync_word[23:16];
         PH_SYNC2: expect_byte = sync_word[15:8];
         default:  expect_byte = sync_word[7:0];
      endcase
   end

   assign count_next = {1'b0, count_ff} + 17'd1;
   assign last       = count_next >= {1'b0, length_ff};

   // next state
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      unique case (phase_ff)
         PH_SYNC0: phase_in = (rx_byte == expect_byte) ? PH_SYNC1 : PH_SYNC0;
         PH_SYNC1: phase_in = (rx_byte == expect_byte) ? PH_SYNC2 : PH_SYNC0;
         PH_SYNC2: phase_in = (rx_byte == expect_byte) ? PH_SYNC3 : PH_SYNC0;
         PH_SYNC3: phase_in = (rx_byte == expect_byte) ? PH_LEN_HI : PH_SYNC0;
         PH_LEN_HI: begin
            length_in = {rx_byte, 8'h00};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {length_ff[15:8], rx_byte};
            count_in  = '0;
            phase_in  = ({length_ff[15:8], rx_byte} > max_payload) ? PH_SYNC0 : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (length_ff != '0 && !last) begin
               count_in = count_next[15:0];
            end else begin
               count_in = '0;
               phase_in = PH_SYNC0;
            end
         end
         default: phase_in = PH_SYNC0;
      endcase
   end

   // outputs
   always_comb begin
      has_result          = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.payload_byte = '0;
      result.byte_offset  = '0;
      result.frame_last   = 1'b0;
      result.frame_length = length_ff;
      unique case (phase_ff)
         PH_LEN_LO: begin
            result.kind         = KIND_LEN_ERR;
            result.frame_length = {length_ff[15:8], rx_byte};
            has_result          = {length_ff[15:8], rx_byte} > max_payload;
         end
         PH_PAYLOAD: begin
            has_result          = length_ff != '0;
            result.payload_byte = rx_byte;
            result.byte_offset  = count_ff;
            result.frame_last   = last;
         end
         default: has_result = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC0;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/sync_length_deframer_top.sv @@
// ----------------------------------------------------------------------------
// sync_length_deframer_top
// byte-stream deframer: sync word hunt, 16-bit length, payload pass-through
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle while req_stall is low. A byte lands
// in an input register, the frame state machine decides on it there, and
// any result moves into the output register, which offers it on rsp_valid.
// rsp_stall holds the output register; the input register keeps taking
// bytes that produce no result, and req_stall rises only when a
// result-bearing byte finds the output register full and stalled. csr
// writes are always ready and take effect at once; write them only while
// the block is idle.
`include "sync_length_deframer_top_defines.svh"

module sync_length_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_byte_offset,
   output logic        rsp_frame_last,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import sld_pkg::*;

   logic [31:0] sync_word_ff;
   logic [15:0] max_payload_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  result;
   logic        has_result;
   logic        out_free;
   logic        advance;
   logic        req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff   <= SYNC_WORD_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYNC_WORD:   sync_word_ff   <= csr_wdata;
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata[15:0];
            default:         sync_word_ff   <= sync_word_ff;
         endcase
      end
   end

   sld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .sync_word   (sync_word_ff),
      .max_payload (max_payload_ff),
      .has_result  (has_result),
      .result      (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && has_result) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_byte_offset  = out_ff.byte_offset;
   assign rsp_frame_last   = out_ff.frame_last;
   assign rsp_frame_length = out_ff.frame_length;

   `SLD_ASSERT_NOW(a_err_fields_zero, rsp_valid && rsp_kind == KIND_LEN_ERR,
      rsp_payload_byte == 8'd0 && rsp_byte_offset == 16'd0 && !rsp_frame_last)
   `SLD_ASSERT_NOW(a_offset_in_frame, rsp_valid && rsp_kind == KIND_PAYLOAD,
      rsp_byte_offset < rsp_frame_length)
   `SLD_ASSERT_NOW(a_last_at_end, rsp_valid && rsp_kind == KIND_PAYLOAD,
      rsp_frame_last == (({1'b0, rsp_byte_offset} + 17'd1) == {1'b0, rsp_frame_length}))
   `SLD_ASSERT_NEXT(a_held_byte_kept, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff))

endmodule
